@@ hdl/kfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfd_pkg
// Shared codes, constants and types for the KISS frame decoder.
// ----------------------------------------------------------------------------
package kfd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned EVENT_W = 2;
    localparam int unsigned PHASE_W = 3;

    localparam logic [COUNT_W-1:0] MAX_FRAME    = COUNT_W'(1024);
    localparam logic [COUNT_W-1:0] CAPACITY_RST = COUNT_W'(1024);

    localparam logic [BYTE_W-1:0] KISS_FEND     = 8'hC0;
    localparam logic [BYTE_W-1:0] KISS_FESC     = 8'hDB;
    localparam logic [BYTE_W-1:0] KISS_TFEND    = 8'hDC;
    localparam logic [BYTE_W-1:0] KISS_TFESC    = 8'hDD;
    localparam logic [BYTE_W-1:0] KISS_CMD_DATA = 8'h00;

    localparam logic [PHASE_W-1:0] PH_WAIT_START = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT_CMD   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DATA       = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ESC        = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE       = 3'd4;

    localparam logic [EVENT_W-1:0] EV_BYTE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_DONE  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_ABORT = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [EVENT_W-1:0] event_res;
        logic [BYTE_W-1:0]  payload_byte;
        logic [COUNT_W-1:0] position;
    } t_result;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [COUNT_W-1:0] count;
    } t_state;

endpackage
`default_nettype wire

@@ hdl/kfd_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfd_step
// Decodes one byte: next framing phase, byte count and optional result.
// ----------------------------------------------------------------------------
module kfd_step (
    input  wire kfd_pkg::t_state                   i_state,
    input  wire logic [kfd_pkg::BYTE_W-1:0]        i_byte,
    input  wire logic [kfd_pkg::COUNT_W-1:0]       i_capacity,
    output kfd_pkg::t_state                        o_state,
    output kfd_pkg::t_result                       o_result
);

    logic [kfd_pkg::PHASE_W-1:0] phase;
    logic [kfd_pkg::COUNT_W-1:0] count;
    logic [kfd_pkg::COUNT_W-1:0] cap_eff;
    logic                        full;
    logic [kfd_pkg::COUNT_W-1:0] count_inc;

    // finished frame is cleared before the byte is decoded
    assign phase     = (i_state.phase == kfd_pkg::PH_DONE) ? kfd_pkg::PH_WAIT_START
                                                           : i_state.phase;
    assign count     = (i_state.phase == kfd_pkg::PH_DONE) ? '0 : i_state.count;
    assign cap_eff   = (i_capacity > kfd_pkg::MAX_FRAME) ? kfd_pkg::MAX_FRAME : i_capacity;
    assign full      = (count >= cap_eff);
    assign count_inc = count + kfd_pkg::COUNT_W'(1);

    always_comb begin
        o_state               = '{phase: phase, count: count};
        o_result              = '0;
        o_result.event_res    = kfd_pkg::EV_BYTE;
        case (phase)
            kfd_pkg::PH_WAIT_CMD: begin
                if (i_byte == kfd_pkg::KISS_CMD_DATA) begin
                    o_state.phase = kfd_pkg::PH_DATA;
                end else if (i_byte == kfd_pkg::KISS_FEND) begin
                    o_state.phase = kfd_pkg::PH_WAIT_CMD;
                end else begin
                    o_state.phase = kfd_pkg::PH_WAIT_START;
                end
            end
            kfd_pkg::PH_DATA: begin
                if (i_byte == kfd_pkg::KISS_FEND) begin
                    o_state.phase      = kfd_pkg::PH_DONE;
                    o_result.valid     = 1'b1;
                    o_result.event_res = kfd_pkg::EV_DONE;
                    o_result.position  = count;
                end else if (i_byte == kfd_pkg::KISS_FESC) begin
                    o_state.phase = kfd_pkg::PH_ESC;
                end else if (!full) begin
                    o_state.count         = count_inc;
                    o_result.valid        = 1'b1;
                    o_result.payload_byte = i_byte;
                    o_result.position     = count;
                end
            end
            kfd_pkg::PH_ESC: begin
                o_state.phase = kfd_pkg::PH_DATA;
                if (i_byte == kfd_pkg::KISS_TFEND ||
                    i_byte == kfd_pkg::KISS_TFESC) begin
                    o_result.valid    = 1'b1;
                    o_result.position = count;
                    if (!full) begin
                        o_state.count         = count_inc;
                        o_result.payload_byte =
                            (i_byte == kfd_pkg::KISS_TFEND) ?
                            kfd_pkg::KISS_FEND : kfd_pkg::KISS_FESC;
                    end else begin
                        // overflow on an escaped byte drops the frame
                        o_state.phase      = kfd_pkg::PH_WAIT_START;
                        o_state.count      = '0;
                        o_result.event_res = kfd_pkg::EV_ABORT;
                    end
                end
            end
            default: begin
                o_state.phase = (i_byte == kfd_pkg::KISS_FEND) ? kfd_pkg::PH_WAIT_CMD
                                                               : kfd_pkg::PH_WAIT_START;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/kiss_frame_decoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kiss_frame_decoder_core
// Removes KISS framing from a received byte stream, one byte per transfer.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_stall   i_rx_byte
//   output   out        o_out_valid / i_out_stall o_event_res, o_payload_byte,
//                                                 o_position
//   config   in         i_cfg_we                  i_cfg_data
//
// one byte per cycle while the output is not stalled; an input transfer reaches the result
// through the input register, then decode into the result register
// a byte producing no result still passes the input register
// synchronous active-low reset; phase, count and valids cleared, capacity set to CAPACITY_RST
// a stalled output holds the pipeline; stall propagates back in the same cycle
// ----------------------------------------------------------------------------
module kiss_frame_decoder_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [kfd_pkg::COUNT_W-1:0]   i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [kfd_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [kfd_pkg::EVENT_W-1:0]        o_event_res,
    output logic [kfd_pkg::BYTE_W-1:0]         o_payload_byte,
    output logic [kfd_pkg::COUNT_W-1:0]        o_position
);

    logic [kfd_pkg::COUNT_W-1:0] r_capacity;
    logic                        r_in_valid;
    logic [kfd_pkg::BYTE_W-1:0]  r_in_byte;
    kfd_pkg::t_state             r_state;
    kfd_pkg::t_state             n_state;
    kfd_pkg::t_result            n_result;
    logic                        r_out_valid;
    logic [kfd_pkg::EVENT_W-1:0] r_event_res;
    logic [kfd_pkg::BYTE_W-1:0]  r_payload_byte;
    logic [kfd_pkg::COUNT_W-1:0] r_position;
    logic                        out_free;
    logic                        advance;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    kfd_step u_step (
        .i_state    (r_state),
        .i_byte     (r_in_byte),
        .i_capacity (r_capacity),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= kfd_pkg::CAPACITY_RST;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: kfd_pkg::PH_WAIT_START, count: '0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && n_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_result.valid) begin
            r_event_res    <= n_result.event_res;
            r_payload_byte <= n_result.payload_byte;
            r_position     <= n_result.position;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_event_res;
    assign o_payload_byte = r_payload_byte;
    assign o_position     = r_position;

    // count never passes the frame limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count <= kfd_pkg::MAX_FRAME)
        else $error("byte count above frame limit");

    // outside a frame the count is always clear
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == kfd_pkg::PH_WAIT_START || r_state.phase == kfd_pkg::PH_WAIT_CMD)
        |-> r_state.count == '0)
        else $error("count held outside a frame");

    // only stored-byte results carry data
    a_event_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_event_res != kfd_pkg::EV_BYTE) |-> r_payload_byte == '0)
        else $error("payload on a non-byte event");

    // a decoded byte that raises a result always lands in the result register
    a_result_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_result.valid) |=> r_out_valid)
        else $error("result lost");

endmodule
`default_nettype wire
